/* design/tpd_pkg.sv */
package tpd_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd1;

  // decode modes
  localparam logic [1:0] MODE_BGR24  = 2'd0;
  localparam logic [1:0] MODE_BGRA32 = 2'd1;
  localparam logic [1:0] MODE_RLE24  = 2'd2;

  // byte position within a pixel
  localparam logic [1:0] PHASE_BLUE  = 2'd0;
  localparam logic [1:0] PHASE_GREEN = 2'd1;
  localparam logic [1:0] PHASE_RED   = 2'd2;
  localparam logic [1:0] PHASE_ALPHA = 2'd3;

  localparam logic [DATA_W-1:0] RUN_FLAG     = 8'd128;
  localparam logic [DATA_W-1:0] RUN_BIAS     = 8'd127;
  localparam logic [DATA_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [DATA_W-1:0] red;
    logic [DATA_W-1:0] green;
    logic [DATA_W-1:0] blue;
    logic [DATA_W-1:0] alpha;
    logic [DATA_W-1:0] repeat_res;
    logic              last_pixel;
  } pixel_t;

endpackage

/* design/tpd_if.sv */
interface tpd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [tpd_pkg::DATA_W-1:0] data_byte;
  logic                      first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface tpd_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [tpd_pkg::DATA_W-1:0] red;
  logic [tpd_pkg::DATA_W-1:0] green;
  logic [tpd_pkg::DATA_W-1:0] blue;
  logic [tpd_pkg::DATA_W-1:0] alpha;
  logic [tpd_pkg::DATA_W-1:0] repeat_res;
  logic                      last_pixel;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_res, output last_pixel, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_res, input last_pixel, output ready);
endinterface

interface tpd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tpd_pkg::CFG_IDX_W-1:0]  index;
  logic [tpd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/tpd_front.sv */
module tpd_front (
  input  logic            clk,
  input  logic            rst,
  tpd_byte_if.sink        byte_in,
  tpd_cfg_if.sink         cfg,
  input  logic            push_ready,
  output logic            push_valid,
  output tpd_pkg::pixel_t push_data
);
  import tpd_pkg::*;

  logic [1:0]         decode_mode;
  logic [COUNT_W-1:0] pixel_count;

  logic [1:0]         byte_phase,      byte_phase_next;
  logic               awaiting_header, awaiting_header_next;
  logic               packet_is_run,   packet_is_run_next;
  logic [DATA_W-1:0]  packet_left,     packet_left_next;
  logic [DATA_W-1:0]  held_blue,       held_blue_next;
  logic [DATA_W-1:0]  held_green,      held_green_next;
  logic [DATA_W-1:0]  held_red,        held_red_next;
  logic [COUNT_W-1:0] pixels_left,     pixels_left_next;

  logic               fire;
  logic               first;
  logic [DATA_W-1:0]  b;
  logic [1:0]         phase_e;
  logic               await_e;
  logic               run_e;
  logic [DATA_W-1:0]  pleft_e;
  logic [COUNT_W-1:0] pl_e;
  logic [DATA_W-1:0]  run_rep;
  logic [DATA_W-1:0]  emit_rep;
  logic [COUNT_W-1:0] pl_after;

  assign cfg.ready     = 1'b1;
  assign byte_in.ready = push_ready;
  assign fire          = byte_in.valid && byte_in.ready;
  assign first         = byte_in.first_byte;
  assign b             = byte_in.data_byte;

  // a first byte restarts the image before it is decoded
  assign phase_e = first ? PHASE_BLUE  : byte_phase;
  assign await_e = first ? 1'b1        : awaiting_header;
  assign run_e   = first ? 1'b0        : packet_is_run;
  assign pleft_e = first ? '0          : packet_left;
  assign pl_e    = first ? pixel_count : pixels_left;

  // an empty run still carries one pixel; never repeat past the image end
  always_comb begin
    run_rep = (pleft_e == '0) ? DATA_W'(1) : pleft_e;
    if (pl_e < COUNT_W'(run_rep)) begin
      run_rep = pl_e[DATA_W-1:0];
    end
  end

  assign emit_rep = (decode_mode == MODE_RLE24 && run_e) ? run_rep : DATA_W'(1);
  assign pl_after = pl_e - COUNT_W'(emit_rep);

  always_comb begin
    byte_phase_next      = byte_phase;
    awaiting_header_next = awaiting_header;
    packet_is_run_next   = packet_is_run;
    packet_left_next     = packet_left;
    held_blue_next       = held_blue;
    held_green_next      = held_green;
    held_red_next        = held_red;
    pixels_left_next     = pixels_left;
    push_valid           = 1'b0;
    push_data.red        = b;
    push_data.green      = held_green;
    push_data.blue       = held_blue;
    push_data.alpha      = ALPHA_OPAQUE;
    push_data.repeat_res = emit_rep;
    push_data.last_pixel = (pl_after == '0);

    if (fire) begin
      if (first) begin
        pixels_left_next     = pixel_count;
        byte_phase_next      = PHASE_BLUE;
        awaiting_header_next = 1'b1;
        packet_is_run_next   = 1'b0;
        packet_left_next     = '0;
      end
      if (pl_e != '0) begin
        case (decode_mode)
          MODE_BGRA32: begin
            case (phase_e)
              PHASE_BLUE: begin
                held_blue_next  = b;
                byte_phase_next = PHASE_GREEN;
              end
              PHASE_GREEN: begin
                held_green_next = b;
                byte_phase_next = PHASE_RED;
              end
              PHASE_RED: begin
                held_red_next   = b;
                byte_phase_next = PHASE_ALPHA;
              end
              default: begin
                byte_phase_next  = PHASE_BLUE;
                pixels_left_next = pl_after;
                push_valid       = 1'b1;
                push_data.red    = held_red;
                push_data.alpha  = b;
              end
            endcase
          end
          MODE_BGR24, MODE_RLE24: begin
            if (decode_mode == MODE_RLE24 && await_e) begin
              if (b < RUN_FLAG) begin
                packet_is_run_next = 1'b0;
                packet_left_next   = b + DATA_W'(1);
              end else begin
                packet_is_run_next = 1'b1;
                packet_left_next   = b - RUN_BIAS;
              end
              awaiting_header_next = 1'b0;
              byte_phase_next      = PHASE_BLUE;
            end else if (phase_e == PHASE_BLUE) begin
              held_blue_next  = b;
              byte_phase_next = PHASE_GREEN;
            end else if (phase_e == PHASE_GREEN) begin
              held_green_next = b;
              byte_phase_next = PHASE_RED;
            end else begin
              // red byte completes the pixel
              held_red_next    = b;
              byte_phase_next  = PHASE_BLUE;
              pixels_left_next = pl_after;
              push_valid       = 1'b1;
              if (decode_mode == MODE_RLE24) begin
                if (run_e || pleft_e <= DATA_W'(1)) begin
                  packet_left_next     = '0;
                  awaiting_header_next = 1'b1;
                end else begin
                  packet_left_next = pleft_e - DATA_W'(1);
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode     <= MODE_BGR24;
      pixel_count     <= '0;
      byte_phase      <= PHASE_BLUE;
      awaiting_header <= 1'b1;
      packet_is_run   <= 1'b0;
      packet_left     <= '0;
      held_blue       <= '0;
      held_green      <= '0;
      held_red        <= '0;
      pixels_left     <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_DECODE_MODE) begin
          decode_mode <= cfg.data[1:0];
        end else if (cfg.index == REG_PIXEL_COUNT) begin
          pixel_count <= cfg.data[COUNT_W-1:0];
        end
      end
      byte_phase      <= byte_phase_next;
      awaiting_header <= awaiting_header_next;
      packet_is_run   <= packet_is_run_next;
      packet_left     <= packet_left_next;
      held_blue       <= held_blue_next;
      held_green      <= held_green_next;
      held_red        <= held_red_next;
      pixels_left     <= pixels_left_next;
    end
  end

endmodule

/* design/tpd_queue.sv */
module tpd_queue #(
  parameter int unsigned DEPTH = tpd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  tpd_pkg::pixel_t push_data,
  output logic            push_ready,
  tpd_pixel_if.source     pixel_out
);
  import tpd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pixel_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;
  pixel_t           head;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pixel_out.valid && pixel_out.ready;
  assign head       = mem[rd_ptr];

  assign pixel_out.valid      = (count != '0);
  assign pixel_out.red        = head.red;
  assign pixel_out.green      = head.green;
  assign pixel_out.blue       = head.blue;
  assign pixel_out.alpha      = head.alpha;
  assign pixel_out.repeat_res = head.repeat_res;
  assign pixel_out.last_pixel = head.last_pixel;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      // hold the count when a word goes in and out together
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* design/tga_pixel_stream_decoder.sv */
// A pixel enters the pixel queue as its last byte is accepted and is offered from there.
// Throughput: one byte per cycle while the queue has room; the decode state is registered.
// byte_in.ready drops only while the pixel queue (QUEUE_DEPTH words) is full.
// Reset (rst, synchronous, active high): decode state cleared with a header awaited,
// mode 0, pixel_count 0, queue empty; bytes are dropped until one flagged as first arrives.
module tga_pixel_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = tpd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  tpd_byte_if.sink    byte_in,
  tpd_cfg_if.sink     cfg,
  tpd_pixel_if.source pixel_out
);
  import tpd_pkg::*;

  logic   push_valid;
  logic   push_ready;
  pixel_t push_data;

  tpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  tpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pixel_out  (pixel_out)
  );

endmodule

/* sim/tga_pixel_stream_decoder_checker.sv */
module tga_pixel_stream_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  tpd_byte_if         byte_ch,
  tpd_cfg_if          cfg_ch,
  tpd_pixel_if        pixel_ch,
  output int unsigned mismatches,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpd_pkg::*;

  logic [1:0]         mode_q;
  logic [COUNT_W-1:0] count_q;
  logic [1:0]         phase_q;
  logic               hdr_wait_q;
  logic               in_run_q;
  logic [DATA_W-1:0]  pkt_left_q;
  logic [DATA_W-1:0]  blue_q;
  logic [DATA_W-1:0]  green_q;
  logic [DATA_W-1:0]  red_q;
  logic [COUNT_W-1:0] left_q;
  pixel_t             expected_pixels[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic queue_pixel(input logic [DATA_W-1:0] alpha, input logic [COUNT_W-1:0] rep);
    pixel_t p;
    left_q       = left_q - rep;
    p.red        = red_q;
    p.green      = green_q;
    p.blue       = blue_q;
    p.alpha      = alpha;
    p.repeat_res = rep[DATA_W-1:0];
    p.last_pixel = (left_q == '0);
    expected_pixels.push_back(p);
  endtask

  task automatic decode_byte(input logic [DATA_W-1:0] b, input logic first);
    logic [COUNT_W-1:0] rep;
    if (first) begin
      left_q     = count_q;
      phase_q    = PHASE_BLUE;
      hdr_wait_q = 1'b1;
      in_run_q   = 1'b0;
      pkt_left_q = '0;
    end
    // drop bytes once the image is done or before it has started
    if (left_q == '0) return;
    case (mode_q)
      MODE_BGRA32: begin
        case (phase_q)
          PHASE_BLUE: begin
            blue_q  = b;
            phase_q = PHASE_GREEN;
          end
          PHASE_GREEN: begin
            green_q = b;
            phase_q = PHASE_RED;
          end
          PHASE_RED: begin
            red_q   = b;
            phase_q = PHASE_ALPHA;
          end
          default: begin
            phase_q = PHASE_BLUE;
            queue_pixel(b, 32'd1);
          end
        endcase
      end
      MODE_BGR24, MODE_RLE24: begin
        if (mode_q == MODE_RLE24 && hdr_wait_q) begin
          if (b < RUN_FLAG) begin
            in_run_q   = 1'b0;
            pkt_left_q = b + 8'd1;
          end else begin
            in_run_q   = 1'b1;
            pkt_left_q = b - RUN_BIAS;
          end
          hdr_wait_q = 1'b0;
          phase_q    = PHASE_BLUE;
        end else if (phase_q == PHASE_BLUE) begin
          blue_q  = b;
          phase_q = PHASE_GREEN;
        end else if (phase_q == PHASE_GREEN) begin
          green_q = b;
          phase_q = PHASE_RED;
        end else begin
          // red, also when a 32-bit image left the phase on alpha
          red_q   = b;
          phase_q = PHASE_BLUE;
          if (mode_q == MODE_BGR24) begin
            queue_pixel(ALPHA_OPAQUE, 32'd1);
          end else if (in_run_q) begin
            rep = (pkt_left_q != '0) ? COUNT_W'(pkt_left_q) : 32'd1;
            if (rep > left_q) rep = left_q;
            pkt_left_q = '0;
            hdr_wait_q = 1'b1;
            queue_pixel(ALPHA_OPAQUE, rep);
          end else begin
            if (pkt_left_q <= 8'd1) begin
              pkt_left_q = '0;
              hdr_wait_q = 1'b1;
            end else begin
              pkt_left_q = pkt_left_q - 8'd1;
            end
            queue_pixel(ALPHA_OPAQUE, 32'd1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      mode_q     = MODE_BGR24;
      count_q    = '0;
      phase_q    = PHASE_BLUE;
      hdr_wait_q = 1'b1;
      in_run_q   = 1'b0;
      pkt_left_q = '0;
      blue_q     = '0;
      green_q    = '0;
      red_q      = '0;
      left_q     = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DECODE_MODE: mode_q  = cfg_ch.data[1:0];
          REG_PIXEL_COUNT: count_q = cfg_ch.data;
          default: ;
        endcase
      end
      if (byte_ch.valid && byte_ch.ready) decode_byte(byte_ch.data_byte, byte_ch.first_byte);
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel word, expected none, got r%0d g%0d b%0d a%0d x%0d l%0d",
                   $time, pixel_ch.red, pixel_ch.green, pixel_ch.blue, pixel_ch.alpha,
                   pixel_ch.repeat_res, pixel_ch.last_pixel);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, pixel_ch.red);
          check_field("green", want.green, pixel_ch.green);
          check_field("blue", want.blue, pixel_ch.blue);
          check_field("alpha", want.alpha, pixel_ch.alpha);
          check_field("repeat_res", want.repeat_res, pixel_ch.repeat_res);
          check_field("last_pixel", DATA_W'(want.last_pixel), DATA_W'(pixel_ch.last_pixel));
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

/* sim/tga_pixel_stream_decoder_tb.sv */
module tga_pixel_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpd_pkg::*;

  localparam logic [1:0]         MODE_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFE_0001;
  localparam int unsigned        TOTAL_BYTES = 850;
  localparam int unsigned        CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;

  tpd_byte_if  byte_if ();
  tpd_cfg_if   cfg_if ();
  tpd_pixel_if pixel_if ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned bytes_sent;
  int unsigned cycles;
  int unsigned image_no;
  logic        restart_next;
  logic [1:0]  img_mode;

  tga_pixel_stream_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_if),
    .cfg       (cfg_if),
    .pixel_out (pixel_if)
  );

  tga_pixel_stream_decoder_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_if),
    .cfg_ch     (cfg_if),
    .pixel_ch   (pixel_if),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    pixel_if.ready = ($urandom_range(99) >= stall_pct);
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [DATA_W-1:0] b, input logic first);
    while ($urandom_range(99) < idle_pct) begin
      byte_if.valid = 1'b0;
      @(negedge clk);
    end
    byte_if.valid      = 1'b1;
    byte_if.data_byte  = b;
    byte_if.first_byte = first;
    do @(posedge clk); while (!byte_if.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_data(input logic [DATA_W-1:0] b);
    send_byte(b, restart_next);
    restart_next = 1'b0;
  endtask

  task automatic send_pixel(input logic [1:0] mode);
    repeat ((mode == MODE_BGRA32) ? 4 : 3) send_data(DATA_W'($urandom_range(255)));
  endtask

  // hold off until every expected pixel has come out and the front is quiet
  task automatic settle();
    byte_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(input logic [1:0] mode, input logic [COUNT_W-1:0] count);
    cfg_if.valid = 1'b1;
    cfg_if.index = REG_DECODE_MODE;
    cfg_if.data  = CFG_DATA_W'(mode);
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.index = REG_PIXEL_COUNT;
    cfg_if.data  = count;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [1:0] pick_mode();
    if ($urandom_range(99) < 4) return MODE_UNUSED;
    case ($urandom_range(2))
      0:       return MODE_BGR24;
      1:       return MODE_BGRA32;
      default: return MODE_RLE24;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (image_no == 1 || r < 3) return COUNT_MAX;
    if (r < 8) return '0;
    return $urandom_range(1, 12);
  endfunction

  task automatic send_rle_pixels(input int unsigned npix);
    int unsigned rem;
    int unsigned n;
    int unsigned used;
    rem = npix;
    while (rem > 0) begin
      if ($urandom_range(3) == 0) n = $urandom_range(1, 128);
      else n = $urandom_range(1, rem);
      used = (n > rem) ? rem : n;
      if ($urandom_range(1)) begin
        send_data(DATA_W'(n + 127));
        send_pixel(MODE_RLE24);
      end else begin
        send_data(DATA_W'(n - 1));
        repeat (used) send_pixel(MODE_RLE24);
      end
      rem -= used;
    end
  endtask

  task automatic send_image();
    logic [COUNT_W-1:0] count;
    int unsigned        npix;
    int unsigned        kind;
    img_mode = pick_mode();
    count    = pick_count();
    image_no++;
    settle();
    write_config(img_mode, count);
    kind = $urandom_range(99);
    if (kind < 12) begin
      // noise, with the odd restart
      repeat ($urandom_range(4, 24))
        send_byte(DATA_W'($urandom_range(255)), $urandom_range(7) == 0);
    end else begin
      npix = (count == 0 || count > 16) ? $urandom_range(1, 16) : count;
      if ($urandom_range(99) < 10) npix = $urandom_range(1, npix);
      restart_next = 1'b1;
      if (img_mode == MODE_RLE24) send_rle_pixels(npix);
      else repeat (npix) send_pixel(img_mode);
      if (kind < 22) begin
        // cut the image short, switch mode and count, carry on
        settle();
        write_config(pick_mode(), pick_count());
        repeat ($urandom_range(3, 12)) send_byte(DATA_W'($urandom_range(255)), 1'b0);
      end else if (kind < 32) begin
        repeat ($urandom_range(1, 6)) send_byte(DATA_W'($urandom_range(255)), 1'b0);
      end
    end
  endtask

  initial begin
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = '0;
    byte_if.first_byte = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_DECODE_MODE;
    cfg_if.data        = '0;
    pixel_if.ready     = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    bytes_sent         = 0;
    cycles             = 0;
    image_no           = 0;
    restart_next       = 1'b0;
    rst                = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // nothing decodes before a first byte
    send_byte(8'hA5, 1'b0);
    settle();
    write_config(MODE_BGR24, 2);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // leave a 32-bit image on its alpha byte, then finish it as 24-bit
    settle();
    write_config(MODE_BGRA32, 2);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b0);
    settle();
    write_config(MODE_BGR24, 2);
    send_byte(8'h77, 1'b0);
    // raw packet of one, then a full-length run clamped to what is left
    settle();
    write_config(MODE_RLE24, 3);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b0);
    settle();
    write_config(MODE_UNUSED, 1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      image_no = 0;
      while (bytes_sent < TOTAL_BYTES * (ph + 1) / 4 + 25) send_image();
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
design/tpd_pkg.sv
design/tpd_if.sv
design/tpd_front.sv
design/tpd_queue.sv
design/tga_pixel_stream_decoder.sv
sim/tga_pixel_stream_decoder_checker.sv
sim/tga_pixel_stream_decoder_tb.sv
